// ===== src/cd_pkg.sv =====
// shared types and codes for the circular deque
// no dependencies
`default_nettype none

package cd_pkg;

	localparam int DATA_W = 32;

	// request mode codes
	localparam logic [2:0] MODE_INS_FRONT = 3'd0;
	localparam logic [2:0] MODE_INS_REAR  = 3'd1;
	localparam logic [2:0] MODE_DEL_FRONT = 3'd2;
	localparam logic [2:0] MODE_DEL_REAR  = 3'd3;
	localparam logic [2:0] MODE_LIST      = 3'd4;

	// response status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		OP_INS_FRONT,
		OP_INS_REAR,
		OP_DEL_FRONT,
		OP_DEL_REAR,
		OP_LIST
	} op_t;

	typedef struct packed {
		logic [2:0]               mode;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} rsp_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	// handshake between command queue and its neighbors
	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage

`default_nettype wire

// ===== src/cd_front.sv =====
// front end: takes request transactions, decodes mode, drops unused codes
// depends on cd_pkg
`default_nettype none

module cd_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  cd_pkg::req_t     req,
	output logic             push,
	output cd_pkg::cmd_t     push_cmd,
	input  wire              q_full
);

	logic         valid_s1;
	cd_pkg::cmd_t cmd_s1;
	cd_pkg::op_t  op_dec;
	logic         keep;
	logic         take;

	always_comb begin
		op_dec = cd_pkg::OP_LIST;
		keep   = 1'b1;
		unique case (req.mode)
			cd_pkg::MODE_INS_FRONT: op_dec = cd_pkg::OP_INS_FRONT;
			cd_pkg::MODE_INS_REAR:  op_dec = cd_pkg::OP_INS_REAR;
			cd_pkg::MODE_DEL_FRONT: op_dec = cd_pkg::OP_DEL_FRONT;
			cd_pkg::MODE_DEL_REAR:  op_dec = cd_pkg::OP_DEL_REAR;
			cd_pkg::MODE_LIST:      op_dec = cd_pkg::OP_LIST;
			default:                keep   = 1'b0;
		endcase
	end

	assign req_stall = valid_s1 && q_full;
	assign push      = valid_s1 && !q_full;
	assign push_cmd  = cmd_s1;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			// unused codes are accepted and dropped here
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op    <= op_dec;
			cmd_s1.value <= req.value;
		end
	end

endmodule

`default_nettype wire

// ===== src/cd_queue.sv =====
// two-entry command queue between front and back ends
// depends on cd_pkg
`default_nettype none

module cd_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  cd_pkg::cmd_t       push_cmd,
	input  wire                pop,
	output cd_pkg::cmd_t       head_cmd,
	output cd_pkg::q_status_t  stat
);

	localparam int QD = 2;
	localparam int QW = $clog2(QD);
	localparam int QC = $clog2(QD + 1);

	cd_pkg::cmd_t   entry_q [QD];
	logic [QW-1:0]  wr_ptr_q;
	logic [QW-1:0]  rd_ptr_q;
	logic [QC-1:0]  cnt_q;

	assign stat.full  = cnt_q == QC'(QD);
	assign stat.valid = cnt_q != '0;
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// ===== src/cd_back.sv =====
// back end: deque storage, head/tail pointers and response register
// depends on cd_pkg
`default_nettype none

module cd_back #(
	parameter int DEPTH = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cmd_valid,
	input  cd_pkg::cmd_t     cmd,
	output logic             cmd_pop,
	output logic             rsp_valid,
	input  wire              rsp_stall,
	output cd_pkg::rsp_t     rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT  = CW'(1);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t                     state_q;
	logic [IW-1:0]              head_q;
	logic [IW-1:0]              tail_q;
	logic [CW-1:0]              count_q;
	logic [IW-1:0]              idx_q;
	logic [CW-1:0]              remain_q;
	logic                       rsp_valid_q;
	cd_pkg::rsp_t               rsp_q;

	logic signed [cd_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic signed [cd_pkg::DATA_W-1:0] rdata_q;

	logic                       out_free;
	logic                       full;
	logic                       empty;
	logic [IW-1:0]              head_inc;
	logic [IW-1:0]              head_dec;
	logic [IW-1:0]              tail_inc;
	logic [IW-1:0]              tail_dec;
	logic [IW-1:0]              idx_inc;
	logic                       we;
	logic                       re;
	logic [IW-1:0]              waddr;
	logic [IW-1:0]              raddr;
	logic                       read_last;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign full      = count_q == FULL_CNT;
	assign empty     = count_q == '0;
	assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign head_dec  = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign tail_inc  = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
	assign tail_dec  = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign idx_inc   = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign read_last = remain_q == ONE_CNT;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid && out_free;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = tail_q;
		raddr = head_q;
		if (cmd_pop) begin
			case (cmd.op)
				cd_pkg::OP_INS_FRONT: begin
					we    = !full;
					waddr = head_dec;
				end
				cd_pkg::OP_INS_REAR: begin
					we    = !full;
					waddr = tail_q;
				end
				cd_pkg::OP_DEL_FRONT: begin
					re    = !empty;
					raddr = head_q;
				end
				cd_pkg::OP_DEL_REAR: begin
					re    = !empty;
					raddr = tail_dec;
				end
				cd_pkg::OP_LIST: begin
					re    = !empty;
					raddr = head_q;
				end
				default: ;
			endcase
		end else if (state_q == S_READ && out_free && !read_last) begin
			// fetch the next listed element while this one goes out
			re    = 1'b1;
			raddr = idx_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= cmd.value;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			remain_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op) inside
							cd_pkg::OP_INS_FRONT, cd_pkg::OP_INS_REAR: begin
								rsp_valid_q <= 1'b1;
								rsp_q.data  <= '0;
								rsp_q.last  <= 1'b1;
								if (full) begin
									rsp_q.status <= cd_pkg::ST_FULL;
								end else begin
									rsp_q.status <= cd_pkg::ST_OK;
									count_q      <= count_q + 1'b1;
									if (cmd.op == cd_pkg::OP_INS_FRONT)
										head_q <= head_dec;
									else
										tail_q <= tail_inc;
								end
							end
							cd_pkg::OP_DEL_FRONT, cd_pkg::OP_DEL_REAR,
							cd_pkg::OP_LIST: begin
								if (empty) begin
									rsp_valid_q  <= 1'b1;
									rsp_q.status <= cd_pkg::ST_EMPTY;
									rsp_q.data   <= '0;
									rsp_q.last   <= 1'b1;
								end else begin
									state_q <= S_READ;
									if (cmd.op == cd_pkg::OP_LIST) begin
										idx_q    <= head_q;
										remain_q <= count_q;
									end else begin
										remain_q <= ONE_CNT;
										count_q  <= count_q - 1'b1;
										if (cmd.op == cd_pkg::OP_DEL_FRONT)
											head_q <= head_inc;
										else
											tail_q <= tail_dec;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_q.status <= cd_pkg::ST_OK;
						rsp_q.data   <= rdata_q;
						rsp_q.last   <= read_last;
						if (read_last) begin
							state_q <= S_IDLE;
						end else begin
							remain_q <= remain_q - 1'b1;
							idx_q    <= idx_inc;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/circular_deque.sv =====
// top level of the circular deque: front decode, command queue, back end
// depends on cd_pkg, cd_front, cd_queue, cd_back
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  cd_pkg::req_t (mode, value)
//   rsp       out         rsp_valid/rsp_stall  cd_pkg::rsp_t (status, data, last)
//
// a taken request passes the decode register and the queue before it is popped
// an insert or a rejected request sets the response register at the pop; a
// delete adds the registered storage read; a list of n gives n responses
// reset zeroes the pointers and occupancy; storage is not cleared
// a stalled response holds the back end; requests are still taken until the
// queue and the decode register are both full
`default_nettype none

module circular_deque #(
	parameter int DEPTH = 8
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  cd_pkg::req_t   req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output cd_pkg::rsp_t   rsp
);

	logic              q_push;
	cd_pkg::cmd_t      q_push_cmd;
	logic              q_pop;
	cd_pkg::cmd_t      q_head_cmd;
	cd_pkg::q_status_t q_stat;

	cd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.q_full    (q_stat.full)
	);

	cd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.head_cmd (q_head_cmd),
		.stat     (q_stat)
	);

	cd_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_stat.valid),
		.cmd       (q_head_cmd),
		.cmd_pop   (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("command pushed into full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.valid)
		else $error("command popped from empty queue");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != cd_pkg::ST_OK) |-> (rsp.last && rsp.data == '0))
		else $error("rejected request response not single or data nonzero");

	a_stall_holds_front: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> q_stat.full)
		else $error("request stalled while queue has room");

endmodule

`default_nettype wire
